// ===== design/lpc_pkg.sv =====
package lpc_pkg;

  localparam int unsigned ADDR_W        = 32;
  localparam int unsigned PAGE_TAG_W    = 23;
  localparam int unsigned SLOT_W        = 3;
  localparam int unsigned OFFSET_W      = 9;
  localparam int unsigned FAULT_W       = 16;
  localparam int unsigned SLOTS_CFG_W   = 4;
  localparam int unsigned CFG_IDX_W     = 2;

  localparam int unsigned SLOTS_DEF     = 8;
  localparam int unsigned PAGE_BITS_DEF = 9;

  localparam logic [ADDR_W-1:0]      SPACE_START_RST  = 32'd512;
  localparam logic [ADDR_W-1:0]      CAPACITY_RST     = 32'd0;
  localparam logic [SLOTS_CFG_W-1:0] SLOTS_IN_USE_RST = 4'd8;

  localparam logic [CFG_IDX_W-1:0] REG_SPACE_START     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_CAPACITY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOTS_IN_USE    = 2'd2;

  localparam logic FUNC_ALLOC  = 1'b0;
  localparam logic FUNC_ACCESS = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_RANGE    = 2'd1,
    STATUS_NO_SPACE = 2'd2
  } status_e;

  typedef struct packed {
    logic              start;
    logic [ADDR_W-1:0] size;
    logic              keep;
  } alloc_req_t;

  typedef struct packed {
    logic              fail;
    logic [ADDR_W-1:0] start_address;
  } alloc_res_t;

  typedef struct packed {
    logic                   start;
    logic [PAGE_TAG_W-1:0]  page;
    logic [SLOTS_CFG_W-1:0] slots_in_use;
  } cache_req_t;

  typedef struct packed {
    logic [SLOT_W-1:0]     slot;
    logic                  hit;
    logic                  wb_valid;
    logic [PAGE_TAG_W-1:0] wb_page;
    logic                  fetch_valid;
    logic [PAGE_TAG_W-1:0] fetch_page;
  } cache_res_t;

endpackage

// ===== design/lpc_alloc.sv =====
module lpc_alloc #(
  parameter int unsigned PAGE_BITS = lpc_pkg::PAGE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lpc_pkg::alloc_req_t            req_i,
  input  logic                           load_i,
  input  logic [lpc_pkg::ADDR_W-1:0]     load_value_i,
  input  logic [lpc_pkg::ADDR_W-1:0]     capacity_i,
  output logic [lpc_pkg::ADDR_W-1:0]     next_free_o,
  output logic                           done_o,
  output lpc_pkg::alloc_res_t            res_o
);

  localparam int unsigned AW = lpc_pkg::ADDR_W;
  localparam logic [AW:0] PageMask = (33'd1 << PAGE_BITS) - 33'd1;

  typedef enum logic [1:0] {
    A_IDLE,
    A_END,
    A_DONE
  } alloc_state_e;

  alloc_state_e        state_q, state_d;
  logic [AW-1:0]       next_free_q, next_free_d;
  logic [AW:0]         start_q, start_d;
  logic [AW-1:0]       size_q, size_d;
  lpc_pkg::alloc_res_t res_q, res_d;

  logic [AW:0]   last_addr;
  logic          crosses;
  logic [AW+1:0] end_addr;

  // The idle state places the region; the end state checks its end against capacity.
  always_comb begin
    last_addr = {1'b0, next_free_q} + {1'b0, req_i.size} - {{AW{1'b0}}, 1'b1};
    crosses   = req_i.keep && (req_i.size != '0) &&
                (({1'b0, next_free_q} >> PAGE_BITS) != (last_addr >> PAGE_BITS));
    end_addr  = {1'b0, start_q} + {2'b00, size_q};

    state_d     = state_q;
    next_free_d = next_free_q;
    start_d     = start_q;
    size_d      = size_q;
    res_d       = res_q;

    case (state_q)
      A_IDLE: begin
        if (load_i) begin
          next_free_d = load_value_i;
        end
        if (req_i.start) begin
          start_d = crosses ? (({1'b0, next_free_q} | PageMask) + {{AW{1'b0}}, 1'b1})
                            : {1'b0, next_free_q};
          size_d  = req_i.size;
          state_d = A_END;
        end
      end
      A_END: begin
        if (end_addr > {2'b00, capacity_i}) begin
          res_d.fail          = 1'b1;
          res_d.start_address = '0;
        end else begin
          res_d.fail          = 1'b0;
          res_d.start_address = start_q[AW-1:0];
          next_free_d         = end_addr[AW-1:0];
        end
        state_d = A_DONE;
      end
      A_DONE: begin
        state_d = A_IDLE;
      end
      default: begin
        state_d = A_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= A_IDLE;
      next_free_q <= lpc_pkg::SPACE_START_RST;
      start_q     <= '0;
      size_q      <= '0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      next_free_q <= next_free_d;
      start_q     <= start_d;
      size_q      <= size_d;
      res_q       <= res_d;
    end
  end

  assign next_free_o = next_free_q;
  assign done_o      = (state_q == A_DONE);
  assign res_o       = res_q;

endmodule

// ===== design/lpc_cache.sv =====
module lpc_cache #(
  parameter int unsigned SLOTS = lpc_pkg::SLOTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  lpc_pkg::cache_req_t             req_i,
  output logic                            done_o,
  output lpc_pkg::cache_res_t             res_o,
  output logic [lpc_pkg::FAULT_W-1:0]     fault_count_o
);

  localparam int unsigned TW   = lpc_pkg::PAGE_TAG_W;
  localparam int unsigned W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CntW = $clog2(SLOTS + 1);
  localparam int unsigned CmpW = (CntW > lpc_pkg::SLOTS_CFG_W) ? CntW : lpc_pkg::SLOTS_CFG_W;

  typedef enum logic [2:0] {
    C_IDLE,
    C_SRCH,
    C_MISS,
    C_EVICT,
    C_UNLINK,
    C_TAIL,
    C_LINK,
    C_DONE
  } cache_state_e;

  // Tag store and the two halves of the doubly linked LRU list.
  logic [TW-1:0] tag_mem  [SLOTS];
  logic [W-1:0]  next_mem [SLOTS];
  logic [W-1:0]  prev_mem [SLOTS];
  logic [TW-1:0] tag_rd_q;
  logic [W-1:0]  next_rd_q;
  logic [W-1:0]  prev_rd_q;

  logic          tag_we, tag_re, link_re, next_we, prev_we;
  logic [W-1:0]  tag_waddr, tag_raddr, link_raddr;
  logic [W-1:0]  next_waddr, next_wdata, prev_waddr, prev_wdata;
  logic [TW-1:0] tag_wdata;

  cache_state_e               state_q, state_d;
  logic [TW-1:0]              page_q, page_d;
  logic [W-1:0]               srch_idx_q, srch_idx_d;
  logic                       cmp_vld_q, cmp_vld_d;
  logic [W-1:0]               slot_q, slot_d;
  logic                       unlink_old_q, unlink_old_d;
  logic [CntW-1:0]            filled_q, filled_d;
  logic [W-1:0]               oldest_q, oldest_d;
  logic [W-1:0]               newest_q, newest_d;
  logic [lpc_pkg::FAULT_W-1:0] evict_cnt_q, evict_cnt_d;
  lpc_pkg::cache_res_t        res_q, res_d;

  logic [CmpW-1:0] slots_ext, enabled;
  logic            fill_ok;
  logic            last_cmp;

  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      tag_mem[tag_waddr] <= tag_wdata;
    end
    if (tag_re) begin
      tag_rd_q <= tag_mem[tag_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    if (link_re) begin
      next_rd_q <= next_mem[link_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) begin
      prev_mem[prev_waddr] <= prev_wdata;
    end
    if (link_re) begin
      prev_rd_q <= prev_mem[link_raddr];
    end
  end

  always_comb begin
    slots_ext = CmpW'(req_i.slots_in_use);
    if (slots_ext == '0) begin
      enabled = CmpW'(1);
    end else if (slots_ext > CmpW'(SLOTS)) begin
      enabled = CmpW'(SLOTS);
    end else begin
      enabled = slots_ext;
    end
    fill_ok  = (CmpW'(filled_q) < enabled);
    last_cmp = ((CntW'(srch_idx_q) + CntW'(1)) == filled_q);

    state_d      = state_q;
    page_d       = page_q;
    srch_idx_d   = srch_idx_q;
    cmp_vld_d    = cmp_vld_q;
    slot_d       = slot_q;
    unlink_old_d = unlink_old_q;
    filled_d     = filled_q;
    oldest_d     = oldest_q;
    newest_d     = newest_q;
    evict_cnt_d  = evict_cnt_q;
    res_d        = res_q;

    tag_we     = 1'b0;
    tag_waddr  = slot_q;
    tag_wdata  = page_q;
    tag_re     = 1'b0;
    tag_raddr  = '0;
    link_re    = 1'b0;
    link_raddr = slot_q;
    next_we    = 1'b0;
    next_waddr = slot_q;
    next_wdata = slot_q;
    prev_we    = 1'b0;
    prev_waddr = slot_q;
    prev_wdata = newest_q;

    case (state_q)
      C_IDLE: begin
        if (req_i.start) begin
          page_d     = req_i.page;
          res_d      = '0;
          cmp_vld_d  = 1'b0;
          srch_idx_d = '0;
          state_d    = (filled_q == '0) ? C_MISS : C_SRCH;
        end
      end
      // One tag is read per cycle; the compare uses the registered read in the cycle after it.
      C_SRCH: begin
        if (cmp_vld_q && (tag_rd_q == page_q)) begin
          slot_d     = srch_idx_q;
          res_d.hit  = 1'b1;
          res_d.slot = lpc_pkg::SLOT_W'(srch_idx_q);
          if (srch_idx_q == newest_q) begin
            state_d = C_DONE;
          end else begin
            link_re      = 1'b1;
            link_raddr   = srch_idx_q;
            unlink_old_d = (srch_idx_q == oldest_q);
            state_d      = C_UNLINK;
          end
        end else if (cmp_vld_q && last_cmp) begin
          state_d = C_MISS;
        end else begin
          tag_re     = 1'b1;
          tag_raddr  = cmp_vld_q ? (srch_idx_q + W'(1)) : '0;
          srch_idx_d = tag_raddr;
          cmp_vld_d  = 1'b1;
        end
      end
      C_MISS: begin
        res_d.fetch_valid = 1'b1;
        res_d.fetch_page  = page_q;
        if (fill_ok) begin
          slot_d     = W'(filled_q);
          res_d.slot = lpc_pkg::SLOT_W'(filled_q);
          filled_d   = filled_q + CntW'(1);
          tag_we     = 1'b1;
          tag_waddr  = W'(filled_q);
          if (filled_q == '0) begin
            oldest_d   = '0;
            newest_d   = '0;
            next_we    = 1'b1;
            next_waddr = '0;
            next_wdata = '0;
            prev_we    = 1'b1;
            prev_waddr = '0;
            prev_wdata = '0;
            state_d    = C_DONE;
          end else begin
            state_d = C_TAIL;
          end
        end else begin
          slot_d     = oldest_q;
          res_d.slot = lpc_pkg::SLOT_W'(oldest_q);
          tag_re     = 1'b1;
          tag_raddr  = oldest_q;
          link_re    = 1'b1;
          link_raddr = oldest_q;
          state_d    = C_EVICT;
        end
      end
      C_EVICT: begin
        res_d.wb_valid = 1'b1;
        res_d.wb_page  = tag_rd_q;
        tag_we         = 1'b1;
        evict_cnt_d    = evict_cnt_q + lpc_pkg::FAULT_W'(1);
        if (slot_q == newest_q) begin
          state_d = C_DONE;
        end else begin
          oldest_d   = next_rd_q;
          prev_we    = 1'b1;
          prev_waddr = next_rd_q;
          prev_wdata = next_rd_q;
          next_we    = 1'b1;
          next_waddr = newest_q;
          next_wdata = slot_q;
          state_d    = C_LINK;
        end
      end
      C_UNLINK: begin
        if (unlink_old_q) begin
          oldest_d   = next_rd_q;
          prev_we    = 1'b1;
          prev_waddr = next_rd_q;
          prev_wdata = next_rd_q;
          next_we    = 1'b1;
          next_waddr = newest_q;
          next_wdata = slot_q;
          state_d    = C_LINK;
        end else begin
          next_we    = 1'b1;
          next_waddr = prev_rd_q;
          next_wdata = next_rd_q;
          prev_we    = 1'b1;
          prev_waddr = next_rd_q;
          prev_wdata = prev_rd_q;
          state_d    = C_TAIL;
        end
      end
      C_TAIL: begin
        next_we    = 1'b1;
        next_waddr = newest_q;
        next_wdata = slot_q;
        state_d    = C_LINK;
      end
      C_LINK: begin
        prev_we    = 1'b1;
        prev_waddr = slot_q;
        prev_wdata = newest_q;
        next_we    = 1'b1;
        next_waddr = slot_q;
        next_wdata = slot_q;
        newest_d   = slot_q;
        state_d    = C_DONE;
      end
      C_DONE: begin
        state_d = C_IDLE;
      end
      default: begin
        state_d = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= C_IDLE;
      page_q       <= '0;
      srch_idx_q   <= '0;
      cmp_vld_q    <= 1'b0;
      slot_q       <= '0;
      unlink_old_q <= 1'b0;
      filled_q     <= '0;
      oldest_q     <= '0;
      newest_q     <= '0;
      evict_cnt_q  <= '0;
      res_q        <= '0;
    end else begin
      state_q      <= state_d;
      page_q       <= page_d;
      srch_idx_q   <= srch_idx_d;
      cmp_vld_q    <= cmp_vld_d;
      slot_q       <= slot_d;
      unlink_old_q <= unlink_old_d;
      filled_q     <= filled_d;
      oldest_q     <= oldest_d;
      newest_q     <= newest_d;
      evict_cnt_q  <= evict_cnt_d;
      res_q        <= res_d;
    end
  end

  assign done_o        = (state_q == C_DONE);
  assign res_o         = res_q;
  assign fault_count_o = evict_cnt_q;

endmodule

// ===== design/lru_page_cache_with_bump_allocator_core.sv =====
// Paged virtual-memory front end for a block device. An allocate item grants
// request_size bytes at a bump pointer, optionally skipping to the next page
// so that the region does not cross a page boundary, and fails with status 2
// when the region would end beyond device_capacity. An access item first
// checks the address against [space_start, bump pointer) and reports status 1
// when it falls outside. Otherwise the page number is looked up in a fully
// associative page cache kept in true LRU order. A miss fills the next free
// slot, or evicts the least recently used slot and requests a writeback of
// the old page; every miss requests a fetch of the new page. fault_count
// reports the number of evictions so far and is valid on every result.
// Items are handled one at a time. The allocator places an allocate item
// and then checks its end against capacity. An out-of-range access goes
// straight to its result; otherwise the tag memory is scanned one entry
// per cycle, and relinking the LRU list writes over the unlink, tail and
// link states on the single write port of each link memory. A finished
// result waits in the output register; the next item is accepted as soon as
// the previous one has moved into it. No clearing pass runs after reset.
// Configuration registers may be written only while no item is in flight;
// writing space_start also reloads the bump pointer.
module lru_page_cache_with_bump_allocator_core #(
  parameter int unsigned SLOTS     = lpc_pkg::SLOTS_DEF,
  parameter int unsigned PAGE_BITS = lpc_pkg::PAGE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              func_i,
  input  logic [lpc_pkg::ADDR_W-1:0]        address_i,
  input  logic [lpc_pkg::ADDR_W-1:0]        request_size_i,
  input  logic                              keep_in_page_i,

  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        status_o,
  output logic [lpc_pkg::ADDR_W-1:0]        start_address_o,
  output logic [lpc_pkg::SLOT_W-1:0]        slot_o,
  output logic [lpc_pkg::OFFSET_W-1:0]      page_offset_o,
  output logic                              hit_o,
  output logic                              writeback_valid_o,
  output logic [lpc_pkg::PAGE_TAG_W-1:0]    writeback_page_o,
  output logic                              fetch_valid_o,
  output logic [lpc_pkg::PAGE_TAG_W-1:0]    fetch_page_o,
  output logic [lpc_pkg::FAULT_W-1:0]       fault_count_o,

  input  logic                              cfg_we_i,
  input  logic [lpc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [lpc_pkg::ADDR_W-1:0]        cfg_data_i
);

  localparam int unsigned AW = lpc_pkg::ADDR_W;
  localparam logic [AW-1:0] PageMask = (32'd1 << PAGE_BITS) - 32'd1;

  typedef enum logic [1:0] {
    T_IDLE,
    T_START,
    T_WAIT,
    T_RESP
  } top_state_e;

  // Configuration registers.
  logic [AW-1:0]                   space_start_q;
  logic [AW-1:0]                   capacity_q;
  logic [lpc_pkg::SLOTS_CFG_W-1:0] slots_in_use_q;
  logic                            load_start;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      space_start_q  <= lpc_pkg::SPACE_START_RST;
      capacity_q     <= lpc_pkg::CAPACITY_RST;
      slots_in_use_q <= lpc_pkg::SLOTS_IN_USE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lpc_pkg::REG_SPACE_START:     space_start_q  <= cfg_data_i;
        lpc_pkg::REG_DEVICE_CAPACITY: capacity_q     <= cfg_data_i;
        lpc_pkg::REG_SLOTS_IN_USE:    slots_in_use_q <= cfg_data_i[lpc_pkg::SLOTS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  assign load_start = cfg_we_i && (cfg_index_i == lpc_pkg::REG_SPACE_START);

  // Item sequencing and the output register.
  top_state_e                      state_q;
  logic                            func_q;
  logic [AW-1:0]                   addr_q;
  logic [AW-1:0]                   size_q;
  logic                            keep_q;
  logic                            range_fail_q;

  logic                            out_valid_q;
  lpc_pkg::status_e                status_q;
  logic [AW-1:0]                   start_address_q;
  lpc_pkg::cache_res_t             cres_q;
  logic [lpc_pkg::OFFSET_W-1:0]    page_offset_q;
  logic [lpc_pkg::FAULT_W-1:0]     fault_count_q;

  lpc_pkg::alloc_req_t             alloc_req;
  lpc_pkg::alloc_res_t             alloc_res;
  logic                            alloc_done;
  logic [AW-1:0]                   next_free;
  lpc_pkg::cache_req_t             cache_req;
  lpc_pkg::cache_res_t             cache_res;
  logic                            cache_done;
  logic [lpc_pkg::FAULT_W-1:0]     fault_count;

  logic                            in_range;
  logic                            out_free;

  assign in_range = (addr_q >= space_start_q) && (addr_q < next_free);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    alloc_req.start = (state_q == T_START) && (func_q == lpc_pkg::FUNC_ALLOC);
    alloc_req.size  = size_q;
    alloc_req.keep  = keep_q;

    cache_req.start        = (state_q == T_START) && (func_q == lpc_pkg::FUNC_ACCESS) &&
                             in_range;
    cache_req.page         = lpc_pkg::PAGE_TAG_W'(addr_q >> PAGE_BITS);
    cache_req.slots_in_use = slots_in_use_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= T_IDLE;
      func_q          <= lpc_pkg::FUNC_ALLOC;
      addr_q          <= '0;
      size_q          <= '0;
      keep_q          <= 1'b0;
      range_fail_q    <= 1'b0;
      out_valid_q     <= 1'b0;
      status_q        <= lpc_pkg::STATUS_OK;
      start_address_q <= '0;
      cres_q          <= '0;
      page_offset_q   <= '0;
      fault_count_q   <= '0;
    end else begin
      // In the response state the output register is reloaded instead.
      if (out_valid_q && out_ready_i && (state_q != T_RESP)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        T_IDLE: begin
          if (in_valid_i) begin
            func_q  <= func_i;
            addr_q  <= address_i;
            size_q  <= request_size_i;
            keep_q  <= keep_in_page_i;
            state_q <= T_START;
          end
        end
        T_START: begin
          // An out-of-range access never reaches the cache.
          range_fail_q <= (func_q == lpc_pkg::FUNC_ACCESS) && !in_range;
          if ((func_q == lpc_pkg::FUNC_ACCESS) && !in_range) begin
            state_q <= T_RESP;
          end else begin
            state_q <= T_WAIT;
          end
        end
        T_WAIT: begin
          if ((func_q == lpc_pkg::FUNC_ALLOC) ? alloc_done : cache_done) begin
            state_q <= T_RESP;
          end
        end
        T_RESP: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            fault_count_q <= fault_count;
            if (func_q == lpc_pkg::FUNC_ALLOC) begin
              // The allocator already reports a start address of zero on failure.
              if (alloc_res.fail) begin
                status_q <= lpc_pkg::STATUS_NO_SPACE;
              end else begin
                status_q <= lpc_pkg::STATUS_OK;
              end
              start_address_q <= alloc_res.start_address;
              cres_q          <= '0;
              page_offset_q   <= '0;
            end else if (range_fail_q) begin
              status_q        <= lpc_pkg::STATUS_RANGE;
              start_address_q <= '0;
              cres_q          <= '0;
              page_offset_q   <= '0;
            end else begin
              status_q        <= lpc_pkg::STATUS_OK;
              start_address_q <= '0;
              cres_q          <= cache_res;
              page_offset_q   <= lpc_pkg::OFFSET_W'(addr_q & PageMask);
            end
            state_q <= T_IDLE;
          end
        end
        default: begin
          state_q <= T_IDLE;
        end
      endcase
    end
  end

  lpc_alloc #(
    .PAGE_BITS (PAGE_BITS)
  ) u_alloc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (alloc_req),
    .load_i       (load_start),
    .load_value_i (cfg_data_i),
    .capacity_i   (capacity_q),
    .next_free_o  (next_free),
    .done_o       (alloc_done),
    .res_o        (alloc_res)
  );

  lpc_cache #(
    .SLOTS (SLOTS)
  ) u_cache (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (cache_req),
    .done_o        (cache_done),
    .res_o         (cache_res),
    .fault_count_o (fault_count)
  );

  assign in_ready_o        = (state_q == T_IDLE);
  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign start_address_o   = start_address_q;
  assign slot_o            = cres_q.slot;
  assign page_offset_o     = page_offset_q;
  assign hit_o             = cres_q.hit;
  assign writeback_valid_o = cres_q.wb_valid;
  assign writeback_page_o  = cres_q.wb_page;
  assign fetch_valid_o     = cres_q.fetch_valid;
  assign fetch_page_o      = cres_q.fetch_page;
  assign fault_count_o     = fault_count_q;

endmodule
